// ----- hw/rtl/wdt_pkg.sv -----
// Shared types, codes, defaults and byte classification for the word dictionary tally.
`default_nettype none
package wdt_pkg;

   // Default sizes handed to the top level parameters.
   localparam int DEF_MAX_ENTRIES   = 256;
   localparam int DEF_MAX_DOCUMENTS = 16;
   localparam int DEF_ENTRY_BYTES   = 64;
   localparam int DEF_TALLY_BITS    = 32;

   // The document number field is four bits wide, so each entry owns 1 << DOC_BITS (16) tally slots.
   localparam int DOC_BITS = 4;

   typedef enum logic [1:0] {
      ACT_DICT = 2'd0,
      ACT_DOC  = 2'd1,
      ACT_END  = 2'd2,
      ACT_READ = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      EV_NONE      = 3'd0,
      EV_COUNTED   = 3'd1,
      EV_UNMATCHED = 3'd2,
      EV_STORED    = 3'd3,
      EV_REJECTED  = 3'd4,
      EV_TALLY     = 3'd5
   } event_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEN_RD,
      ST_LEN_CHK,
      ST_BYTE_RD,
      ST_BYTE_CHK,
      ST_TALLY_RD,
      ST_TALLY_UPD,
      ST_EMIT
   } state_type;

   // Whitespace, punctuation and digits end a word; every other byte belongs to a word.
   function automatic logic word_char(input logic [7:0] c);
      logic ws;
      logic printable;
      logic alpha;
      ws        = c inside {[8'h09:8'h0D]};
      printable = c inside {[8'h20:8'h7E]};
      alpha     = c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
      return !ws && (!printable || alpha);
   endfunction

   // Lowercase ASCII A-Z only.
   function automatic logic [7:0] to_lower(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c inside {[8'h41:8'h5A]}) begin
         r = c + 8'd32;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/wdt_dict.sv -----
// Dictionary storage: entry bytes and entry lengths, each with one write and one registered read port.
`default_nettype none
module wdt_dict #(
   parameter int MAX_ENTRIES = wdt_pkg::DEF_MAX_ENTRIES,
   parameter int ENTRY_BYTES = wdt_pkg::DEF_ENTRY_BYTES,
   localparam int SLOT  = ENTRY_BYTES - 1,
   localparam int DEPTH = MAX_ENTRIES * SLOT,
   localparam int DAW   = $clog2(DEPTH),
   localparam int EW    = $clog2(MAX_ENTRIES),
   localparam int LW    = $clog2(ENTRY_BYTES + 1)
) (
   input  wire logic           clock,
   input  wire logic           byte_we,
   input  wire logic [DAW-1:0] byte_waddr,
   input  wire logic [7:0]     byte_wdata,
   input  wire logic [DAW-1:0] byte_raddr,
   output logic      [7:0]     byte_rdata,
   input  wire logic           len_we,
   input  wire logic [EW-1:0]  len_waddr,
   input  wire logic [LW-1:0]  len_wdata,
   input  wire logic [EW-1:0]  len_raddr,
   output logic      [LW-1:0]  len_rdata
);

   logic [7:0]    byte_mem [DEPTH];
   logic [LW-1:0] len_mem  [MAX_ENTRIES];

   // Entry bytes, packed one slot per entry.
   always_ff @(posedge clock) begin
      if (byte_we) begin
         byte_mem[byte_waddr] <= byte_wdata;
      end
      byte_rdata <= byte_mem[byte_raddr];
   end

   // Entry lengths.
   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[len_waddr] <= len_wdata;
      end
      len_rdata <= len_mem[len_raddr];
   end

endmodule
`default_nettype wire

// ----- hw/rtl/wdt_tally.sv -----
// Tally memory with a clearing pass after reset and one registered read port.
`default_nettype none
module wdt_tally #(
   parameter int MAX_ENTRIES = wdt_pkg::DEF_MAX_ENTRIES,
   parameter int TALLY_BITS  = wdt_pkg::DEF_TALLY_BITS,
   localparam int DEPTH = MAX_ENTRIES * (1 << wdt_pkg::DOC_BITS),
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   output logic                       busy,
   input  wire logic                  we,
   input  wire logic [AW-1:0]         addr,
   input  wire logic [TALLY_BITS-1:0] wdata,
   output logic      [TALLY_BITS-1:0] rdata
);

   logic [TALLY_BITS-1:0] mem [DEPTH];
   logic [AW-1:0]         clr_ff;
   logic [AW-1:0]         clr_in;
   logic                  busy_ff;
   logic                  busy_in;

   // Sweep pointer for the clearing pass.
   always_comb begin
      clr_in  = clr_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == AW'(DEPTH - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         clr_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         clr_ff  <= clr_in;
      end
   end

   // Storage: zero fill while clearing, otherwise the requested write.
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_ff] <= '0;
      end else if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

   assign busy = busy_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/word_dictionary_tally_top.sv -----
// Top level of the word dictionary tally: stream ports, sequencer, word buffer and result register.
//
// Each transfer in gives exactly one transfer out. After reset the block clears its tally
// memory and takes no item meanwhile. A dictionary byte, a document letter, an end of
// document, a byte that ends no word or a word end answered without a search passes
// through the accepting state and the hand-off state that moves the result to the output
// register. A tally read also passes through the tally read and tally update states. A
// word end that searches uses one shared byte comparator: it fetches each entry's length,
// compares byte by byte for entries whose length equals the word's, and updates the tally
// when an entry matches. A result that waits on rsp_tready holds the block in its hand-off
// state. The search loop over the dictionary memory sets the rate of word ends.
`default_nettype none
module word_dictionary_tally_top #(
   parameter int MAX_ENTRIES   = wdt_pkg::DEF_MAX_ENTRIES,
   parameter int MAX_DOCUMENTS = wdt_pkg::DEF_MAX_DOCUMENTS,
   parameter int ENTRY_BYTES   = wdt_pkg::DEF_ENTRY_BYTES,
   parameter int TALLY_BITS    = wdt_pkg::DEF_TALLY_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // ch[7:0], file_index[11:8], word_index[19:12], zero
   input  wire logic [1:0]  req_tuser,  // action[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [39:0] rsp_tdata,  // entry_number[7:0], tally[39:8]
   output logic      [2:0]  rsp_tuser   // event_res[2:0]
);

   localparam int SLOT  = ENTRY_BYTES - 1;
   localparam int DAW   = $clog2(MAX_ENTRIES * SLOT);
   localparam int EW    = $clog2(MAX_ENTRIES);
   localparam int ETW   = $clog2(MAX_ENTRIES + 1);
   localparam int LW    = $clog2(ENTRY_BYTES + 1);
   localparam int WBW   = $clog2(SLOT);
   localparam int DW    = wdt_pkg::DOC_BITS;

   // Request fields.
   wdt_pkg::action_type act;
   logic [7:0]          ch;
   logic [DW-1:0]       file_index;
   logic [7:0]          word_index;
   logic                accept;

   assign act        = wdt_pkg::action_type'(req_tuser);
   assign ch         = req_tdata[7:0];
   assign file_index = req_tdata[11:8];
   assign word_index = req_tdata[19:12];

   // Registers.
   wdt_pkg::state_type  state_ff, state_in;
   logic [ETW-1:0]      entry_total_ff, entry_total_in;
   logic [LW-1:0]       load_len_ff, load_len_in;
   logic [DAW-1:0]      load_base_ff, load_base_in;
   logic [LW-1:0]       word_len_ff, word_len_in;
   logic                in_word_ff, in_word_in;
   logic [LW-1:0]       slen_ff, slen_in;
   logic [EW-1:0]       e_ff, e_in;
   logic [DAW-1:0]      base_ff, base_in;
   logic [WBW-1:0]      i_ff, i_in;
   logic [DW-1:0]       doc_ff, doc_in;
   logic                read_ff, read_in;
   wdt_pkg::event_type  res_ev_ff, res_ev_in;
   logic [7:0]          res_num_ff, res_num_in;
   logic [31:0]         res_tally_ff, res_tally_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          rsp_ev_ff, rsp_ev_in;
   logic [7:0]          rsp_num_ff, rsp_num_in;
   logic [31:0]         rsp_tally_ff, rsp_tally_in;

   // Memory ports.
   logic                  byte_we;
   logic [DAW-1:0]        byte_waddr;
   logic [7:0]            byte_rdata;
   logic                  len_we;
   logic [LW-1:0]         len_rdata;
   logic                  word_we;
   logic [WBW-1:0]        word_waddr;
   logic [7:0]            word_rd_ff;
   logic [7:0]            word_mem [SLOT];
   logic                  tally_busy;
   logic                  tally_we;
   logic [TALLY_BITS-1:0] tally_wdata;
   logic [TALLY_BITS-1:0] tally_rdata;
   logic [LW-1:0]         cur_len;

   assign req_tready = (state_ff == wdt_pkg::ST_IDLE) && !tally_busy;
   assign accept     = req_tvalid && req_tready;
   assign byte_waddr = load_base_ff + DAW'(load_len_ff);
   assign cur_len    = in_word_ff ? word_len_ff : '0;
   assign word_waddr = cur_len[WBW-1:0];

   wdt_dict #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .ENTRY_BYTES (ENTRY_BYTES)
   ) u_dict (
      .clock      (clock),
      .byte_we    (byte_we),
      .byte_waddr (byte_waddr),
      .byte_wdata (ch),
      .byte_raddr (base_ff + DAW'(i_ff)),
      .byte_rdata (byte_rdata),
      .len_we     (len_we),
      .len_waddr  (entry_total_ff[EW-1:0]),
      .len_wdata  (load_len_ff),
      .len_raddr  (e_ff),
      .len_rdata  (len_rdata)
   );

   wdt_tally #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .TALLY_BITS  (TALLY_BITS)
   ) u_tally (
      .clock (clock),
      .reset (reset),
      .busy  (tally_busy),
      .we    (tally_we),
      .addr  ({e_ff, doc_ff}),
      .wdata (tally_wdata),
      .rdata (tally_rdata)
   );

   // Pending word buffer, read one byte at a time by the comparator.
   always_ff @(posedge clock) begin
      if (word_we) begin
         word_mem[word_waddr] <= ch;
      end
      word_rd_ff <= word_mem[i_ff];
   end

   // Sequencer: item decode, dictionary search, tally update and result hand-off.
   always_comb begin
      state_in       = state_ff;
      entry_total_in = entry_total_ff;
      load_len_in    = load_len_ff;
      load_base_in   = load_base_ff;
      word_len_in    = word_len_ff;
      in_word_in     = in_word_ff;
      slen_in        = slen_ff;
      e_in           = e_ff;
      base_in        = base_ff;
      i_in           = i_ff;
      doc_in         = doc_ff;
      read_in        = read_ff;
      res_ev_in      = res_ev_ff;
      res_num_in     = res_num_ff;
      res_tally_in   = res_tally_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_ev_in      = rsp_ev_ff;
      rsp_num_in     = rsp_num_ff;
      rsp_tally_in   = rsp_tally_ff;
      byte_we        = 1'b0;
      len_we         = 1'b0;
      word_we        = 1'b0;
      tally_we       = 1'b0;
      tally_wdata    = (tally_rdata == '1) ? tally_rdata : tally_rdata + 1'b1;

      case (state_ff)
         wdt_pkg::ST_IDLE: begin
            if (accept) begin
               state_in     = wdt_pkg::ST_EMIT;
               doc_in       = file_index;
               res_ev_in    = wdt_pkg::EV_NONE;
               res_num_in   = '0;
               res_tally_in = '0;
               case (act)
                  wdt_pkg::ACT_DICT: begin
                     if (ch != 8'd0) begin
                        if (32'(load_len_ff) < SLOT) begin
                           byte_we     = 32'(entry_total_ff) < MAX_ENTRIES;
                           load_len_in = load_len_ff + 1'b1;
                        end else begin
                           load_len_in = LW'(ENTRY_BYTES);
                           res_ev_in   = wdt_pkg::EV_REJECTED;
                           res_num_in  = 8'(entry_total_ff);
                        end
                     end else if (load_len_ff != '0) begin
                        load_len_in = '0;
                        res_num_in  = 8'(entry_total_ff);
                        if (32'(load_len_ff) > SLOT || 32'(entry_total_ff) >= MAX_ENTRIES)
                        begin
                           res_ev_in = wdt_pkg::EV_REJECTED;
                        end else begin
                           len_we         = 1'b1;
                           res_ev_in      = wdt_pkg::EV_STORED;
                           entry_total_in = entry_total_ff + 1'b1;
                           load_base_in   = load_base_ff + DAW'(SLOT);
                        end
                     end
                  end
                  wdt_pkg::ACT_DOC: begin
                     if (wdt_pkg::word_char(ch)) begin
                        in_word_in = 1'b1;
                        if (32'(cur_len) < SLOT) begin
                           word_we     = 1'b1;
                           word_len_in = cur_len + 1'b1;
                        end else begin
                           word_len_in = LW'(ENTRY_BYTES);
                        end
                     end else if (in_word_ff) begin
                        // A word ends here: start the search or answer at once.
                        in_word_in  = 1'b0;
                        word_len_in = '0;
                        slen_in     = word_len_ff;
                        e_in        = '0;
                        base_in     = '0;
                        i_in        = '0;
                        read_in     = 1'b0;
                        if (32'(word_len_ff) < 2) begin
                           res_ev_in = wdt_pkg::EV_NONE;
                        end else if (32'(word_len_ff) > SLOT || entry_total_ff == '0) begin
                           res_ev_in = wdt_pkg::EV_UNMATCHED;
                        end else begin
                           state_in = wdt_pkg::ST_LEN_RD;
                        end
                     end
                  end
                  wdt_pkg::ACT_END: begin
                     in_word_in  = 1'b0;
                     word_len_in = '0;
                  end
                  wdt_pkg::ACT_READ: begin
                     res_num_in = word_index;
                     e_in       = EW'(word_index);
                     read_in    = 1'b1;
                     if (32'(word_index) < 32'(entry_total_ff) &&
                         32'(file_index) < MAX_DOCUMENTS) begin
                        state_in = wdt_pkg::ST_TALLY_RD;
                     end else begin
                        res_ev_in = wdt_pkg::EV_REJECTED;
                     end
                  end
                  default: begin
                     state_in = wdt_pkg::ST_EMIT;
                  end
               endcase
            end
         end

         wdt_pkg::ST_LEN_RD: begin
            state_in = wdt_pkg::ST_LEN_CHK;
         end

         wdt_pkg::ST_LEN_CHK,
         wdt_pkg::ST_BYTE_CHK: begin
            if (state_ff == wdt_pkg::ST_LEN_CHK && len_rdata == slen_ff) begin
               i_in     = '0;
               state_in = wdt_pkg::ST_BYTE_RD;
            end else if (state_ff == wdt_pkg::ST_BYTE_CHK &&
                         wdt_pkg::to_lower(word_rd_ff) == byte_rdata) begin
               if (32'(i_ff) + 1 == 32'(slen_ff)) begin
                  // Whole word equal: this entry is the match.
                  res_num_in = 8'(e_ff);
                  if (32'(doc_ff) < MAX_DOCUMENTS) begin
                     state_in = wdt_pkg::ST_TALLY_RD;
                  end else begin
                     res_ev_in = wdt_pkg::EV_REJECTED;
                     state_in  = wdt_pkg::ST_EMIT;
                  end
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = wdt_pkg::ST_BYTE_RD;
               end
            end else begin
               // Move on to the next entry, or give up after the last one.
               i_in = '0;
               if (32'(e_ff) + 1 >= 32'(entry_total_ff)) begin
                  res_ev_in = wdt_pkg::EV_UNMATCHED;
                  state_in  = wdt_pkg::ST_EMIT;
               end else begin
                  e_in     = e_ff + 1'b1;
                  base_in  = base_ff + DAW'(SLOT);
                  state_in = wdt_pkg::ST_LEN_RD;
               end
            end
         end

         wdt_pkg::ST_BYTE_RD: begin
            state_in = wdt_pkg::ST_BYTE_CHK;
         end

         wdt_pkg::ST_TALLY_RD: begin
            state_in = wdt_pkg::ST_TALLY_UPD;
         end

         wdt_pkg::ST_TALLY_UPD: begin
            state_in = wdt_pkg::ST_EMIT;
            if (read_ff) begin
               res_ev_in    = wdt_pkg::EV_TALLY;
               res_tally_in = 32'(tally_rdata);
            end else begin
               tally_we     = 1'b1;
               res_ev_in    = wdt_pkg::EV_COUNTED;
               res_tally_in = 32'(tally_wdata);
            end
         end

         wdt_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_ev_in    = res_ev_ff;
               rsp_num_in   = res_num_ff;
               rsp_tally_in = res_tally_ff;
               state_in     = wdt_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = wdt_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= wdt_pkg::ST_IDLE;
         entry_total_ff <= '0;
         load_len_ff    <= '0;
         load_base_ff   <= '0;
         word_len_ff    <= '0;
         in_word_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_total_ff <= entry_total_in;
         load_len_ff    <= load_len_in;
         load_base_ff   <= load_base_in;
         word_len_ff    <= word_len_in;
         in_word_ff     <= in_word_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Search and result payload.
   always_ff @(posedge clock) begin
      slen_ff      <= slen_in;
      e_ff         <= e_in;
      base_ff      <= base_in;
      i_ff         <= i_in;
      doc_ff       <= doc_in;
      read_ff      <= read_in;
      res_ev_ff    <= res_ev_in;
      res_num_ff   <= res_num_in;
      res_tally_ff <= res_tally_in;
      rsp_ev_ff    <= rsp_ev_in;
      rsp_num_ff   <= rsp_num_in;
      rsp_tally_ff <= rsp_tally_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_tally_ff, rsp_num_ff};
   assign rsp_tuser  = rsp_ev_ff;

endmodule
`default_nettype wire
